// ===== hw/rtl/cfri_pkg.sv =====
`default_nettype none

package cfri_pkg;

  // Default widths of the stream counters.
  localparam int POS_BITS_DEF   = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Row numbers always use the full width of the result field.
  localparam int ROW_BITS = 32;

  // Field widths of the result channel.
  localparam int OUT_POS_BITS   = 32;
  localparam int OUT_COUNT_BITS = 16;

  // Byte codes with a fixed meaning.
  localparam logic [7:0] BYTE_NUL     = 8'd0;
  localparam logic [7:0] BYTE_CR      = 8'd13;
  localparam logic [7:0] BYTE_LF      = 8'd10;
  localparam logic [7:0] BYTE_QUOTE   = 8'd34;
  localparam logic [7:0] DELIM_RESET  = 8'd59;

  // Input action codes.
  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_EOF  = 1'b1;

  // Queue between the classifier and the state engine.
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = Q_PTR_BITS + 1;
  localparam logic [Q_CNT_BITS-1:0] Q_FULL_CNT = Q_CNT_BITS'(Q_DEPTH);

  // Classified operation carried through the queue.
  typedef enum logic [2:0] {
    OP_TEXT,
    OP_QUOTE,
    OP_DELIM,
    OP_NEWLINE,
    OP_EOF
  } op_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_FIELD = 2'd0,
    KIND_ROW   = 2'd1,
    KIND_EOF   = 2'd2
  } kind_t;

  // One queue entry with its valid flag.
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cfri_front.sv =====
`default_nettype none

module cfri_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_wdata,
  input  wire logic            in_valid,
  input  wire logic            in_stall,
  input  wire logic            in_action,
  input  wire logic [7:0]      in_text_byte,
  output cfri_pkg::q_req_t     push
);

  logic [7:0] delimiter_r;
  logic       accept;
  logic       drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r <= cfri_pkg::DELIM_RESET;
    end else if (cfg_we) begin
      delimiter_r <= cfg_wdata;
    end
  end

  assign accept = in_valid && !in_stall;

  // NUL and CR vanish here and never reach the queue.
  assign drop = (in_action == cfri_pkg::ACTION_BYTE) &&
                (in_text_byte inside {cfri_pkg::BYTE_NUL, cfri_pkg::BYTE_CR});

  // Priority: end of file, quote, delimiter, newline, anything else.
  always_comb begin
    push.valid = accept && !drop;
    if (in_action == cfri_pkg::ACTION_EOF) begin
      push.op = cfri_pkg::OP_EOF;
    end else if (in_text_byte == cfri_pkg::BYTE_QUOTE) begin
      push.op = cfri_pkg::OP_QUOTE;
    end else if (in_text_byte == delimiter_r) begin
      push.op = cfri_pkg::OP_DELIM;
    end else if (in_text_byte == cfri_pkg::BYTE_LF) begin
      push.op = cfri_pkg::OP_NEWLINE;
    end else begin
      push.op = cfri_pkg::OP_TEXT;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cfri_queue.sv =====
`default_nettype none

module cfri_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfri_pkg::q_req_t  push,
  input  wire logic              pop,
  output logic                   full,
  output cfri_pkg::q_req_t       head
);

  cfri_pkg::op_t                     mem_r [cfri_pkg::Q_DEPTH];
  logic [cfri_pkg::Q_PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [cfri_pkg::Q_CNT_BITS-1:0]   count_r, count_nxt;
  logic                              do_push, do_pop;

  assign full       = (count_r == cfri_pkg::Q_FULL_CNT);
  assign head.valid = (count_r != '0);
  assign head.op    = mem_r[rd_ptr_r];

  // The front only pushes while not full; the back only pops a valid head.
  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cfri_back.sv =====
`default_nettype none

module cfri_back #(
  parameter int POS_BITS   = cfri_pkg::POS_BITS_DEF,
  parameter int COUNT_BITS = cfri_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire cfri_pkg::q_req_t                     head,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                out_kind,
  output logic [cfri_pkg::OUT_POS_BITS-1:0]         out_position,
  output logic [cfri_pkg::ROW_BITS-1:0]             out_row_number,
  output logic [cfri_pkg::OUT_COUNT_BITS-1:0]       out_field_count,
  output logic                                      out_row_mismatch,
  output logic                                      out_file_ok
);

  logic                              in_quotes_r,  in_quotes_nxt;
  logic [POS_BITS-1:0]               offset_r,     offset_nxt;
  logic [COUNT_BITS-1:0]             fields_r,     fields_nxt;
  logic [COUNT_BITS-1:0]             expected_r,   expected_nxt;
  logic [cfri_pkg::ROW_BITS-1:0]     row_r,        row_nxt;
  logic                              healthy_r,    healthy_nxt;

  logic                              out_valid_r,  out_valid_nxt;
  cfri_pkg::kind_t                   kind_r,       kind_nxt;
  logic [POS_BITS-1:0]               pos_r,        pos_nxt;
  logic [cfri_pkg::ROW_BITS-1:0]     orow_r,       orow_nxt;
  logic [COUNT_BITS-1:0]             ocount_r,     ocount_nxt;
  logic                              mismatch_r,   mismatch_nxt;
  logic                              ok_r,         ok_nxt;

  logic                              emit;

  // A result slot is free when empty or being taken this cycle.
  assign pop = head.valid && (!out_valid_r || !out_stall);

  always_comb begin
    in_quotes_nxt = in_quotes_r;
    offset_nxt    = offset_r;
    fields_nxt    = fields_r;
    expected_nxt  = expected_r;
    row_nxt       = row_r;
    healthy_nxt   = healthy_r;
    emit          = 1'b0;
    kind_nxt      = kind_r;
    pos_nxt       = offset_r;
    orow_nxt      = row_r;
    ocount_nxt    = fields_r;
    mismatch_nxt  = 1'b0;
    ok_nxt        = healthy_r;

    if (pop) begin
      if (head.op == cfri_pkg::OP_EOF) begin
        emit     = 1'b1;
        kind_nxt = cfri_pkg::KIND_EOF;
        // With no newline seen the open row gives the column count.
        if (row_r != cfri_pkg::ROW_BITS'(1)) begin
          ocount_nxt = expected_r;
        end
        in_quotes_nxt = 1'b0;
        offset_nxt    = '0;
        fields_nxt    = COUNT_BITS'(1);
        expected_nxt  = '0;
        row_nxt       = cfri_pkg::ROW_BITS'(1);
        healthy_nxt   = 1'b1;
      end else begin
        if (offset_r != '1) begin
          offset_nxt = offset_r + 1'b1;
        end
        if (head.op == cfri_pkg::OP_QUOTE) begin
          in_quotes_nxt = !in_quotes_r;
        end else if (!in_quotes_r) begin
          case (head.op)
            cfri_pkg::OP_DELIM: begin
              if (fields_r != '1) begin
                fields_nxt = fields_r + 1'b1;
              end
              emit       = 1'b1;
              kind_nxt   = cfri_pkg::KIND_FIELD;
              ocount_nxt = fields_nxt;
            end
            cfri_pkg::OP_NEWLINE: begin
              if (expected_r == '0) begin
                expected_nxt = fields_r;
              end else if (expected_r != fields_r) begin
                mismatch_nxt = 1'b1;
                healthy_nxt  = 1'b0;
              end
              emit       = 1'b1;
              kind_nxt   = cfri_pkg::KIND_ROW;
              ok_nxt     = healthy_nxt;
              fields_nxt = COUNT_BITS'(1);
              if (row_r != '1) begin
                row_nxt = row_r + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      offset_r    <= '0;
      fields_r    <= COUNT_BITS'(1);
      expected_r  <= '0;
      row_r       <= cfri_pkg::ROW_BITS'(1);
      healthy_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      in_quotes_r <= in_quotes_nxt;
      offset_r    <= offset_nxt;
      fields_r    <= fields_nxt;
      expected_r  <= expected_nxt;
      row_r       <= row_nxt;
      healthy_r   <= healthy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind_r     <= kind_nxt;
      pos_r      <= pos_nxt;
      orow_r     <= orow_nxt;
      ocount_r   <= ocount_nxt;
      mismatch_r <= mismatch_nxt;
      ok_r       <= ok_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_position     = cfri_pkg::OUT_POS_BITS'(pos_r);
  assign out_row_number   = orow_r;
  assign out_field_count  = cfri_pkg::OUT_COUNT_BITS'(ocount_r);
  assign out_row_mismatch = mismatch_r;
  assign out_file_ok      = ok_r;

`ifndef SYNTH
  // A flagged row always clears the health flag it reports.
  a_mismatch_clears_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mismatch_r |-> !ok_r)
    else $error("row mismatch reported with file_ok set");

  // Only row ends can carry a mismatch.
  a_mismatch_on_row_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r != cfri_pkg::KIND_ROW) |-> !mismatch_r)
    else $error("mismatch on a non-row result");

  // A held result is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !pop)
    else $error("result register loaded while stalled");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/csv_field_row_indexer.sv =====
// Channel   Direction  Handshake           Payload
// cfg       in         cfg_we              cfg_wdata (delimiter byte)
// in        in         in_valid/in_stall   in_action, in_text_byte
// out       out        out_valid/out_stall out_kind, out_position, out_row_number,
//                                          out_field_count, out_row_mismatch, out_file_ok
//
// One request is taken per clock while in_stall is low; the sustained rate is
// one byte per cycle while out_stall is low. A request is first stored in the
// queue, and its result is then held in the result register of the state engine.
// The four-entry queue sets how far the input runs ahead of a stalled output;
// in_stall rises only when that queue is full.
// Reset is synchronous and active low; it restores the delimiter to ';' and
// the stream counters to the start of a file.
`default_nettype none

module csv_field_row_indexer #(
  parameter int POS_BITS   = cfri_pkg::POS_BITS_DEF,
  parameter int COUNT_BITS = cfri_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [7:0]                         cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_action,
  input  wire logic [7:0]                         in_text_byte,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_kind,
  output logic [cfri_pkg::OUT_POS_BITS-1:0]       out_position,
  output logic [cfri_pkg::ROW_BITS-1:0]           out_row_number,
  output logic [cfri_pkg::OUT_COUNT_BITS-1:0]     out_field_count,
  output logic                                    out_row_mismatch,
  output logic                                    out_file_ok
);

  // The front classifies each request against the delimiter and drops NUL
  // and CR bytes, so they take no queue slot and never move the position.
  cfri_pkg::q_req_t push;
  cfri_pkg::q_req_t head;
  logic             pop;
  logic             q_full;

  // The input side stalls only on a full queue, never on the output stall,
  // so a waiting result does not block new requests.
  assign in_stall = q_full;

  cfri_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_text_byte (in_text_byte),
    .push         (push)
  );

  cfri_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // The back holds the quote flag, offset, field and row counters and the
  // health flag, and drives the result register.
  cfri_back #(
    .POS_BITS   (POS_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_position     (out_position),
    .out_row_number   (out_row_number),
    .out_field_count  (out_field_count),
    .out_row_mismatch (out_row_mismatch),
    .out_file_ok      (out_file_ok)
  );

endmodule

`default_nettype wire

// ===== sim/tb_csv_field_row_indexer.sv =====
module tb_csv_field_row_indexer;
  timeunit 1ns;
  timeprecision 1ps;

  import cfri_pkg::*;

  // A request passes the queue and then the result register before it is
  // answered. Its four-entry queue can still hold bytes that give no result,
  // so the bench keeps waiting before the stream is taken as idle.
  localparam int DRAIN_CYCLES = 12;
  // How long the receiver refuses results in the back-pressure test.
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_BUDGET = 340;

  // One result of the indexer as the predictor expects it.
  typedef struct {
    kind_t                     kind;
    logic [OUT_POS_BITS-1:0]   position;
    logic [ROW_BITS-1:0]       row_number;
    logic [OUT_COUNT_BITS-1:0] field_count;
    logic                      row_mismatch;
    logic                      file_ok;
  } csv_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = ACTION_BYTE;
  logic [7:0] in_text_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [OUT_POS_BITS-1:0] out_position;
  logic [ROW_BITS-1:0] out_row_number;
  logic [OUT_COUNT_BITS-1:0] out_field_count;
  logic out_row_mismatch;
  logic out_file_ok;

  csv_field_row_indexer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_position     (out_position),
    .out_row_number   (out_row_number),
    .out_field_count  (out_field_count),
    .out_row_mismatch (out_row_mismatch),
    .out_file_ok      (out_file_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the delimiter register and of the stream state.
  logic [7:0]                delim_reg = DELIM_RESET;
  logic                      quoted;
  logic [POS_BITS_DEF-1:0]   offset;
  logic [COUNT_BITS_DEF-1:0] fields;
  logic [COUNT_BITS_DEF-1:0] first_row_fields;
  logic [ROW_BITS-1:0]       row_no;
  logic                      healthy_flag;

  // Results still owed by the block, oldest first.
  csv_event_t pending_csv_events[$];

  int err_count = 0;
  int items_sent = 0;
  int in_stall_cycles = 0;
  int boundaries_seen = 0;
  int rows_seen = 0;
  int summaries_seen = 0;
  int flagged_rows_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  // The test raises hold_reqs; the receiver answers each one with a hold-off.
  int hold_reqs = 0;
  int hold_acks = 0;
  csv_event_t want;

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // A new file starts with no quote open, position zero and row one.
  task automatic clear_stream();
    quoted = 1'b0;
    offset = '0;
    fields = 1;
    first_row_fields = '0;
    row_no = 1;
    healthy_flag = 1'b1;
  endtask

  task automatic push_event(input kind_t kind, input logic [POS_BITS_DEF-1:0] pos,
                            input logic [COUNT_BITS_DEF-1:0] count,
                            input logic mismatch);
    csv_event_t ev;
    ev.kind         = kind;
    ev.position     = OUT_POS_BITS'(pos);
    ev.row_number   = row_no;
    ev.field_count  = OUT_COUNT_BITS'(count);
    ev.row_mismatch = mismatch;
    ev.file_ok      = healthy_flag;
    pending_csv_events = {pending_csv_events, ev};
  endtask

  // Advances the predicted index by one accepted request and queues the
  // result that it causes, if any.
  task automatic update_csv_index(input logic action, input logic [7:0] data);
    logic [POS_BITS_DEF-1:0] at;
    logic flag;
    if (action == ACTION_EOF) begin
      // With no newline seen yet the open row decides the column count.
      push_event(KIND_EOF, offset, (row_no == 1) ? fields : first_row_fields, 1'b0);
      clear_stream();
      return;
    end
    // NUL and CR vanish from the cleaned stream, even as the delimiter.
    if (data == BYTE_NUL || data == BYTE_CR) return;
    at = offset;
    if (offset != '1) offset++;
    // A quote toggles the quoted region and never acts as a delimiter.
    if (data == BYTE_QUOTE) begin
      quoted = !quoted;
      return;
    end
    if (quoted) return;
    // The delimiter wins over newline when both are the same byte.
    if (data == delim_reg) begin
      if (fields != '1) fields++;
      push_event(KIND_FIELD, at, fields, 1'b0);
      return;
    end
    if (data == BYTE_LF) begin
      flag = 1'b0;
      if (first_row_fields == '0) begin
        first_row_fields = fields;
      end else if (first_row_fields != fields) begin
        flag = 1'b1;
        healthy_flag = 1'b0;
      end
      push_event(KIND_ROW, at, fields, flag);
      fields = 1;
      if (row_no != '1) row_no++;
    end
  endtask

  // Offers one request, with an optional gap first, and waits until the
  // block takes it. The payload is held steady while the block stalls.
  task automatic send_request(input logic action, input logic [7:0] data);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= action;
    in_text_byte <= data;
    @(posedge clk);
    while (in_stall) begin
      in_stall_cycles++;
      @(posedge clk);
    end
    update_csv_index(action, data);
    if (action == ACTION_EOF || (data != BYTE_NUL && data != BYTE_CR)) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(ACTION_BYTE, s[i]);
  endtask

  // Stops offering requests until every owed result is in, then lets the
  // queue settle so that a register write finds the block idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_csv_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_delimiter(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    delim_reg = value;
  endtask

  // A field of random text. Quoted fields may hold delimiters and newlines;
  // a quote inside the text is sent doubled, as CSV escapes it.
  task automatic send_random_field();
    int len;
    logic in_q;
    logic [7:0] b;
    len  = $urandom_range(0, 4);
    in_q = ($urandom_range(3) == 0);
    if (in_q) send_request(ACTION_BYTE, BYTE_QUOTE);
    repeat (len) begin
      b = 8'($urandom);
      if (b == BYTE_QUOTE) begin
        send_request(ACTION_BYTE, BYTE_QUOTE);
      end else if (!in_q && (b == delim_reg || b == BYTE_LF)) begin
        b = "x";
      end
      send_request(ACTION_BYTE, b);
    end
    if (in_q) send_request(ACTION_BYTE, BYTE_QUOTE);
  endtask

  // A small file: most rows share one column count, some do not, the last
  // row may be left open, and now and then raw noise precedes the end marker.
  task automatic send_random_file();
    int cols;
    int nrows;
    int nf;
    cols  = $urandom_range(1, 5);
    nrows = $urandom_range(1, 5);
    for (int r = 0; r < nrows; r++) begin
      nf = ($urandom_range(5) == 0) ? $urandom_range(1, 6) : cols;
      for (int f = 0; f < nf; f++) begin
        if (f != 0) send_request(ACTION_BYTE, delim_reg);
        send_random_field();
      end
      if (r != nrows - 1 || $urandom_range(3) != 0) begin
        if ($urandom_range(3) == 0) send_request(ACTION_BYTE, BYTE_CR);
        send_request(ACTION_BYTE, BYTE_LF);
      end
    end
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        send_request(($urandom_range(15) == 0) ? ACTION_EOF : ACTION_BYTE, 8'($urandom));
      end
    end
    send_request(ACTION_EOF, 8'($urandom));
  endtask

  // Short files under the reset delimiter: dropped bytes, a quoted region
  // holding a delimiter and a newline, a flagged row, an open last row,
  // an empty file and a one-row file.
  task automatic test_directed();
    send_idle_pct  = 33;
    recv_stall_pct = 69;
    send_text("a;");
    send_request(ACTION_BYTE, BYTE_NUL);
    send_request(ACTION_BYTE, BYTE_CR);
    send_text("b\n\";\n\";");
    send_request(ACTION_BYTE, 8'hFF);
    send_text("\n");
    send_request(ACTION_BYTE, 8'h80);
    send_text("\nx;");
    send_request(ACTION_EOF, 8'hFF);
    send_request(ACTION_EOF, 8'h00);
    send_text("z;");
    send_request(ACTION_EOF, 8'h7F);
    wait_drained();
  endtask

  // Delimiters that collide with the fixed byte codes, NUL among them, plus the top byte 8'hFF.
  task automatic test_delimiters();
    logic [7:0] picks[5];
    picks = '{BYTE_NUL, BYTE_CR, BYTE_QUOTE, BYTE_LF, 8'hFF};
    foreach (picks[i]) begin
      write_delimiter(picks[i]);
      send_request(ACTION_BYTE, picks[i]);
      send_request(ACTION_BYTE, BYTE_LF);
      send_request(ACTION_EOF, 8'h00);
      wait_drained();
    end
  endtask

  // The receiver holds off while the sender keeps offering field boundaries,
  // so the queue fills and the block must stall its input.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_delimiter(DELIM_RESET);
    hold_reqs++;
    repeat (40) send_request(ACTION_BYTE, DELIM_RESET);
    send_request(ACTION_BYTE, BYTE_LF);
    send_request(ACTION_EOF, 8'h00);
    wait_drained();
  endtask

  task automatic run_random_phase(input int s_pct, input int r_pct, input logic [7:0] d);
    int start;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    write_delimiter(d);
    start = items_sent;
    while (items_sent - start < RANDOM_BUDGET) send_random_file();
    wait_drained();
  endtask

  // Random files under three idling patterns and three delimiters.
  task automatic test_random_files();
    run_random_phase(33, 69, DELIM_RESET);
    run_random_phase(69, 33, 8'hFF);
    run_random_phase(0, 0, ",");
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_reqs != hold_acks) begin
      hold_acks = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every accepted result must match the oldest owed one in every field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_csv_events.size() == 0) begin
        note_error($sformatf("unexpected result kind %0d pos %0d row %0d count %0d",
                             out_kind, out_position, out_row_number, out_field_count));
      end else begin
        want = pending_csv_events.pop_front();
        case (want.kind)
          KIND_FIELD: boundaries_seen++;
          KIND_ROW:   rows_seen++;
          default:    summaries_seen++;
        endcase
        if (want.row_mismatch) flagged_rows_seen++;
        if (out_kind !== want.kind || out_position !== want.position ||
            out_row_number !== want.row_number || out_field_count !== want.field_count ||
            out_row_mismatch !== want.row_mismatch || out_file_ok !== want.file_ok) begin
          note_error($sformatf(
            "expected kind %0d pos %0d row %0d count %0d mis %0b ok %0b, got %0d %0d %0d %0d %0b %0b",
            want.kind, want.position, want.row_number, want.field_count, want.row_mismatch,
            want.file_ok, out_kind, out_position, out_row_number, out_field_count,
            out_row_mismatch, out_file_ok));
        end
      end
    end
  end

  initial begin
    clear_stream();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_delimiters();
    test_backpressure();
    test_random_files();

    for (int i = 0; i < 20000 && pending_csv_events.size() != 0; i++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_csv_events.size() != 0) begin
      note_error($sformatf("%0d results never arrived", pending_csv_events.size()));
    end

    $display("Checked %0d boundaries, %0d row ends (%0d flagged), %0d file totals",
             boundaries_seen, rows_seen, flagged_rows_seen, summaries_seen);
    $display("%0d counted requests sent; input held back by the block for %0d cycles",
             items_sent, in_stall_cycles);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Safety net for a hung handshake.
  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cfri_pkg.sv
hw/rtl/cfri_front.sv
hw/rtl/cfri_queue.sv
hw/rtl/cfri_back.sv
hw/rtl/csv_field_row_indexer.sv
sim/tb_csv_field_row_indexer.sv
